[rtl/core/bcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants for the button click event detector
// Field widths, phase and event codes, register map and reset values.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int MASK_W   = 3;   // pressed_mask width
  localparam int KEY_W    = 2;   // event_key width
  localparam int KIND_W   = 2;   // event_kind width
  localparam int TICK_W   = 16;  // per-key tick timer and thresholds
  localparam int PHASE_W  = 3;
  localparam int ADDR_W   = 4;   // three registers at byte offsets 0, 4, 8
  localparam int REG_IDX_W = 2;
  localparam int DATA_W   = 32;

  // Key phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DEBOUNCE = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PRESSED  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAITING  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_LONG     = 3'd4;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_SINGLE = 2'd0;
  localparam logic [KIND_W-1:0] EV_DOUBLE = 2'd1;
  localparam logic [KIND_W-1:0] EV_LONG   = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_DBL_WIN  = 2'd2;

  localparam logic [TICK_W-1:0] RST_DEBOUNCE = 16'd2;
  localparam logic [TICK_W-1:0] RST_LONG     = 16'd100;
  localparam logic [TICK_W-1:0] RST_DBL_WIN  = 16'd30;

  typedef struct packed {
    logic [TICK_W-1:0] debounce;
    logic [TICK_W-1:0] long_press;
    logic [TICK_W-1:0] dbl_window;
  } cfg_t;

  typedef struct packed {
    logic              fired;
    logic [KIND_W-1:0] kind;
  } lane_res_t;

  // Packed so that present is bit 0, key bits 2:1, kind bits 4:3
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic              present;
  } evt_t;

endpackage

[rtl/core/bcd_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_lane: per-key click state machine
// Debounce, press, second-press wait and long-press tracking for one key.
// ----------------------------------------------------------------------------
module bcd_lane
  import bcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,   // one tick taken this cycle
  input  logic      down,
  input  cfg_t      cfg,
  output lane_res_t res        // event of the current tick, valid with advance
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic               dbl_r, dbl_nxt;
  logic               long_r, long_nxt;
  logic [TICK_W-1:0]  t;

  always_comb begin
    phase_nxt = phase_r;
    dbl_nxt   = dbl_r;
    long_nxt  = long_r;
    t         = ticks_r;
    res       = '0;
    case (phase_r)
      PH_IDLE: begin
        if (down) begin
          phase_nxt = PH_DEBOUNCE;
          dbl_nxt   = 1'b0;
        end
        t = '0;
      end
      PH_DEBOUNCE: begin
        if (ticks_r >= cfg.debounce) begin
          if (down) begin
            phase_nxt = PH_PRESSED;
            t         = '0;
            long_nxt  = 1'b0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (!down) begin
          phase_nxt = PH_WAITING;
          t         = '0;
        end else if (ticks_r >= cfg.long_press) begin
          if (!long_r) begin
            res.fired = 1'b1;
            res.kind  = EV_LONG;
            long_nxt  = 1'b1;
          end
          phase_nxt = PH_LONG;
        end
      end
      PH_WAITING: begin
        if (down) begin
          if (ticks_r >= cfg.debounce) begin
            res.fired = 1'b1;
            res.kind  = EV_DOUBLE;
            dbl_nxt   = 1'b1;
            phase_nxt = PH_DEBOUNCE;
          end
        end else if (ticks_r >= cfg.dbl_window) begin
          if (!dbl_r) begin
            res.fired = 1'b1;
            res.kind  = EV_SINGLE;
          end
          phase_nxt = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (!down) begin
          phase_nxt = PH_IDLE;
          long_nxt  = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        t         = '0;
      end
    endcase
    ticks_nxt = t + 1'b1;  // wraps at the timer width
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ticks_r <= '0;
      dbl_r   <= 1'b0;
      long_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      dbl_r   <= dbl_nxt;
      long_r  <= long_nxt;
    end
  end

endmodule

[rtl/core/bcd_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_merge: event merge across key lanes
// Report the highest-numbered lane that fired; all zeros when none did.
// ----------------------------------------------------------------------------
module bcd_merge
  import bcd_pkg::*;
#(
  parameter int NUM_KEYS = 3
) (
  input  lane_res_t res [NUM_KEYS],
  output evt_t      evt
);

  always_comb begin
    evt = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (res[k].fired) begin
        evt.present = 1'b1;
        evt.key     = KEY_W'(k);   // keep the low key bits
        evt.kind    = res[k].kind;
      end
    end
  end

endmodule

[rtl/core/button_click_event_detector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_event_detector_core: single / double / long press detector
// Per-key debounce and click classification with one event word per tick.
// ----------------------------------------------------------------------------
// Each input word is one tick and carries one pressed bit per key. Every key
// has its own lane (a five-phase state machine with a 16-bit wrapping tick
// timer and double/long flags); all lanes step together on the accepted
// word, and a merge stage picks the highest-numbered key that fired. Exactly
// one result word leaves per tick: event_present, event_key and event_kind,
// all zero when no key fired. Throughput is one tick per clock while the
// output register can take a word; that register holds the result word. A
// new tick is taken while that register is empty or is being drained the
// same cycle. Thresholds sit in three APB registers (debounce at 0x0, long
// press at 0x4, double-click window at 0x8, low 16 bits used); write them
// only while no tick is in flight. Keys beyond the three mask bits never
// see a press, and key indexes wrap to two bits.
// ----------------------------------------------------------------------------
module button_click_event_detector_core
  import bcd_pkg::*;
#(
  parameter int NUM_KEYS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input tick stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,     // [2:0] pressed_mask, [7:3] zero
  // Result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,    // [0] event_present, [2:1] event_key,
                                          // [4:3] event_kind, [7:5] zero
  // Configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t                 cfg_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce   <= RST_DEBOUNCE;
      cfg_r.long_press <= RST_LONG;
      cfg_r.dbl_window <= RST_DBL_WIN;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE: cfg_r.debounce   <= cfg_pwdata[TICK_W-1:0];
        REG_LONG:     cfg_r.long_press <= cfg_pwdata[TICK_W-1:0];
        REG_DBL_WIN:  cfg_r.dbl_window <= cfg_pwdata[TICK_W-1:0];
        default: ;    // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE: cfg_prdata = DATA_W'(cfg_r.debounce);
      REG_LONG:     cfg_prdata = DATA_W'(cfg_r.long_press);
      REG_DBL_WIN:  cfg_prdata = DATA_W'(cfg_r.dbl_window);
      default:      cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: advance the lanes whenever the output register can take a word
  // --------------------------------------------------------------------------
  logic out_valid_r;
  evt_t out_evt_r;
  logic in_take;

  assign in_tready = !out_valid_r || out_tready;
  assign in_take   = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Key lanes
  // --------------------------------------------------------------------------
  lane_res_t lane_res [NUM_KEYS];
  logic [NUM_KEYS-1:0] key_down;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    if (k < MASK_W) begin : g_wired
      assign key_down[k] = in_tdata[k];
    end else begin : g_absent
      assign key_down[k] = 1'b0;   // no mask bit for this key
    end

    bcd_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (in_take),
      .down    (key_down[k]),
      .cfg     (cfg_r),
      .res     (lane_res[k])
    );
  end

  // --------------------------------------------------------------------------
  // Merge and output register
  // --------------------------------------------------------------------------
  evt_t merged;

  bcd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .res (lane_res),
    .evt (merged)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_evt_r <= merged;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_evt_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_quiet_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_evt_r.present |-> out_evt_r.key == '0 && out_evt_r.kind == '0)
    else $error("event word without event carries nonzero key or kind");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_evt_r.kind == EV_SINGLE || out_evt_r.kind == EV_DOUBLE ||
                    out_evt_r.kind == EV_LONG)
    else $error("unknown event kind on output");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && !out_tready)
    else $error("input stalled with room in the output register");

  a_take_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid_r)
    else $error("accepted tick did not produce a result word");

endmodule
